/* design/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the sorted record table
// Record layout, action and status codes, and the default table depth.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int KEY_W    = 27;
    localparam int CODE_W   = 16;
    localparam int NUM_W    = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    // action codes; the unused code behaves as a read
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [CODE_W-1:0]        code;
        logic signed [NUM_W-1:0]  number;
    } t_rec;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        t_rec                rec;
    } t_result;

endpackage

/* design/srt_cell.sv */
// ----------------------------------------------------------------------------
// srt_cell: one record slot of the circulating table
// Holds a record and takes its neighbour's record on every shift cycle.
// ----------------------------------------------------------------------------
module srt_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  srt_pkg::t_rec  i_rec,
    output srt_pkg::t_rec  o_rec
);

    srt_pkg::t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

/* design/sorted_record_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_record_table_top: record table kept in ascending key order
// Records circulate through a ring of cells; the head cell is inspected.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one transfer per action (insert, update, read).
//   Output stream (m_axis_*): exactly one result transfer per action.
//   Each action makes one full lap of the ring, one shift per table position,
//   during which position t of the table sits in the head cell at shift t.
//   Insert slips the new record in through a one-record carry stage, so all
//   later records move up by one place; update rewrites the matching record
//   as it passes; read captures the record at the requested position.
//   The result is loaded into the output register once the lap is over;
//   no new action is taken until then, so actions never overlap.
//   s_axis_tready is high only while no lap is in progress. A finished result
//   waits in the output register; a new action may be accepted meanwhile,
//   and its lap stalls at the end until the previous result is taken.
//   Reset empties the table (count zero); record storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_record_table_top #(
    parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], id_key[28:2], code_in[44:29], number_in[76:45],
    // read_index[83:77], zero fill [87:84]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], position[9:3], key_out[36:10], code_out[52:37],
    // number_out[84:53], entry_count[92:85], zero fill [95:93]
    output logic [95:0] m_axis_tdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured action
    logic [srt_pkg::ACTION_W-1:0] r_act;
    logic [srt_pkg::KEY_W-1:0]    r_key;
    logic [srt_pkg::CODE_W-1:0]   r_code;
    logic signed [srt_pkg::NUM_W-1:0] r_num;
    logic [srt_pkg::POS_W-1:0]    r_idx;

    logic [IW-1:0] r_t;
    logic [CW-1:0] r_count;
    logic          r_done, n_done;
    logic          r_ins, n_ins;
    srt_pkg::t_rec r_carry, n_carry;
    srt_pkg::t_result r_res, n_res;

    srt_pkg::t_result r_out;
    logic [CW-1:0]    r_out_count;
    logic             r_out_valid;

    srt_pkg::t_rec w_q [TABLE_DEPTH];
    srt_pkg::t_rec w_d [TABLE_DEPTH];
    srt_pkg::t_rec n_tail;
    srt_pkg::t_rec w_head;
    srt_pkg::t_rec w_new;

    logic w_shift, w_last, w_in_range, w_ge, w_eq, w_full, w_accept, w_load;
    logic [CW-1:0] w_new_count;
    srt_pkg::t_result w_final;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign w_d[g] = n_tail;
            end else begin : g_body
                assign w_d[g] = w_q[g+1];
            end
            srt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_rec   (w_d[g]),
                .o_rec   (w_q[g])
            );
        end
    endgenerate

    assign w_head     = w_q[0];
    assign w_new      = '{key: r_key, code: r_code, number: r_num};
    assign w_shift    = (r_state == S_RUN);
    assign w_last     = (r_t == IW'(TABLE_DEPTH - 1));
    assign w_in_range = (32'(r_t) < 32'(r_count));
    assign w_ge       = !w_in_range || (w_head.key >= r_key);
    assign w_eq       = w_in_range && (w_head.key == r_key);
    assign w_full     = (32'(r_count) >= 32'(TABLE_DEPTH));
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // head inspection, one table position per cycle
    always_comb begin
        n_tail  = w_head;
        n_carry = r_carry;
        n_done  = r_done;
        n_ins   = r_ins;
        n_res   = r_res;
        if (r_ins) begin
            n_tail  = r_carry;
            n_carry = w_head;
        end else if (!r_done) begin
            case (r_act)
                srt_pkg::ACT_INSERT: begin
                    if (w_ge) begin
                        n_done = 1'b1;
                        if (w_eq) begin
                            n_res = '{status: srt_pkg::ST_DUP,
                                      position: srt_pkg::POS_W'(r_t), rec: w_head};
                        end else if (w_full) begin
                            n_res = '{status: srt_pkg::ST_FULL, position: '0, rec: '0};
                        end else begin
                            n_tail  = w_new;
                            n_carry = w_head;
                            n_ins   = 1'b1;
                            n_res   = '{status: srt_pkg::ST_INSERTED,
                                        position: srt_pkg::POS_W'(r_t), rec: w_new};
                        end
                    end
                end
                srt_pkg::ACT_UPDATE: begin
                    if (w_ge) begin
                        n_done = 1'b1;
                        if (w_eq) begin
                            n_tail = '{key: w_head.key, code: r_code, number: r_num};
                            n_res  = '{status: srt_pkg::ST_UPDATED,
                                       position: srt_pkg::POS_W'(r_t), rec: n_tail};
                        end else begin
                            n_res = '{status: srt_pkg::ST_ABSENT, position: '0, rec: '0};
                        end
                    end
                end
                default: begin
                    if (32'(r_t) == 32'(r_idx)) begin
                        n_done = 1'b1;
                        if (w_in_range) begin
                            n_res = '{status: srt_pkg::ST_READ,
                                      position: srt_pkg::POS_W'(r_t), rec: w_head};
                        end else begin
                            n_res = '{status: srt_pkg::ST_FULL, position: '0, rec: '0};
                        end
                    end
                end
            endcase
        end
    end

    // undecided at the end of the lap: full insert, absent key or bad index
    always_comb begin
        w_final = r_res;
        if (!r_done) begin
            w_final = '{status: (r_act == srt_pkg::ACT_UPDATE) ? srt_pkg::ST_ABSENT
                                                                : srt_pkg::ST_FULL,
                        position: '0, rec: '0};
        end
    end

    assign w_new_count = r_ins ? r_count + CW'(1) : r_count;
    assign w_load = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_t         <= '0;
            r_done      <= 1'b0;
            r_ins       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_t    <= '0;
                r_done <= 1'b0;
                r_ins  <= 1'b0;
            end else if (w_shift) begin
                r_t    <= r_t + IW'(1);
                r_done <= n_done;
                r_ins  <= n_ins;
            end
            if (w_load) begin
                r_count     <= w_new_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= s_axis_tdata[1:0];
            r_key  <= s_axis_tdata[28:2];
            r_code <= s_axis_tdata[44:29];
            r_num  <= s_axis_tdata[76:45];
            r_idx  <= s_axis_tdata[83:77];
        end
        if (w_shift) begin
            r_carry <= n_carry;
            r_res   <= n_res;
        end
        if (w_load) begin
            r_out       <= w_final;
            r_out_count <= w_new_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, srt_pkg::COUNT_W'(r_out_count), r_out.rec.number,
                            r_out.rec.code, r_out.rec.key, r_out.position, r_out.status};

endmodule

/* design/srt_checker.sv */
// ----------------------------------------------------------------------------
// srt_checker: port-level checks for the sorted record table
// Watches both streams of the top level; attached by bind.
// ----------------------------------------------------------------------------
module srt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= srt_pkg::ST_FULL)
        else $error("status code out of range");

    // one action at a time: busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during a lap");

    // a result never appears the cycle after an action is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");

endmodule

bind sorted_record_table_top srt_checker u_srt_checker (.*);
